>>> hdl/multi_channel_deadline_timer_defines.svh
// Assertion macros for the multi-channel deadline timer.
`ifndef MULTI_CHANNEL_DEADLINE_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_DEADLINE_TIMER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MDT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mdt: same-cycle check failed");
// next-cycle implication
`define MDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mdt: next-cycle check failed");
`else
`define MDT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MDT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hdl/mdt_pkg.sv
// Shared types and constants of the multi-channel deadline timer.
`timescale 1ns / 1ps
package mdt_pkg;

   localparam int NUM_CHANNELS = 32;
   localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);

   localparam int OPCODE_W = 3;
   localparam int CHAN_W   = 5;
   localparam int TIME_W   = 32;
   localparam int TAG_W    = 8;
   localparam int KIND_W   = 2;
   localparam int CSR_W    = 6;

   localparam logic [TIME_W-1:0] EVENT_BASE  = 32'h0200_0000;
   localparam logic [TIME_W-1:0] NO_DEADLINE = 32'hffff_ffff;
   localparam logic [CSR_W-1:0]  TASK_NONE   = 6'd32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK    = 3'd0,
      OP_ALLOC   = 3'd1,
      OP_FREE    = 3'd2,
      OP_SET_TAG = 3'd3,
      OP_START   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      CH_FREE  = 2'd0,
      CH_ALLOC = 2'd1,
      CH_RUN   = 2'd2
   } chan_status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC       = 2'd0,
      KIND_NONE_FREE   = 2'd1,
      KIND_EXPIRY      = 2'd2,
      KIND_TASK_SWITCH = 2'd3
   } rsp_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_FLUSH = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      chan_status_type   status;
      logic [TIME_W-1:0] deadline;
      logic [TAG_W-1:0]  tag;
   } chan_entry_type;

   typedef struct packed {
      rsp_kind_type      kind;
      logic [CHAN_W-1:0] channel_out;
      logic [TAG_W-1:0]  tag_out;
      logic [TIME_W-1:0] event_word;
      logic              last;
   } rsp_word_type;

   typedef struct packed {
      logic                busy;
      logic                scanning;
      logic [CH_IDX_W-1:0] step;
   } ctrl_status_type;

endpackage

>>> hdl/mdt_if.sv
// Request and response channel interfaces of the deadline timer.
`timescale 1ns / 1ps
interface mdt_req_if import mdt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [CHAN_W-1:0]   channel;
   logic [TIME_W-1:0]   duration;
   logic [TAG_W-1:0]    tag_in;

   modport source (output valid, opcode, channel, duration, tag_in, input ready);
   modport sink (input valid, opcode, channel, duration, tag_in, output ready);
endinterface

interface mdt_rsp_if import mdt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [CHAN_W-1:0] channel_out;
   logic [TAG_W-1:0]  tag_out;
   logic [TIME_W-1:0] event_word;
   logic              last;

   modport source (output valid, kind, channel_out, tag_out, event_word, last, input ready);
   modport sink (input valid, kind, channel_out, tag_out, event_word, last, output ready);
endinterface

>>> hdl/mdt_cell.sv
// One channel slot of the rotating channel ring.
`timescale 1ns / 1ps
module mdt_cell import mdt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           shift,
   input  chan_entry_type entry_d,
   output chan_entry_type entry_q
);

   chan_status_type   status_ff, status_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;

   always_comb begin
      status_in   = status_ff;
      deadline_in = deadline_ff;
      tag_in      = tag_ff;
      if (shift) begin
         status_in   = entry_d.status;
         deadline_in = entry_d.deadline;
         tag_in      = entry_d.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= CH_FREE;
      end else begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      tag_ff      <= tag_in;
   end

   assign entry_q = '{status: status_ff, deadline: deadline_ff, tag: tag_ff};

endmodule

>>> hdl/mdt_ctrl.sv
// Head unit: sequencer, per-channel update at the ring head and result staging.
`timescale 1ns / 1ps
module mdt_ctrl import mdt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   mdt_req_if.sink            req_ch,
   mdt_rsp_if.source          rsp_ch,
   input  logic               csr_wr_en,
   input  logic [CSR_W-1:0]   csr_wr_data,
   input  chan_entry_type     head_entry,
   output chan_entry_type     tail_entry,
   output logic               shift,
   output ctrl_status_type    stat
);

   localparam int CMP_W = (CH_IDX_W > CSR_W) ? CH_IDX_W : CSR_W;

   ctrl_state_type      state_ff, state_in;
   logic [CSR_W-1:0]    task_ff, task_in;
   logic [TIME_W-1:0]   tick_ff, tick_in;
   logic [TIME_W-1:0]   earliest_ff, earliest_in;
   logic [CH_IDX_W-1:0] step_ff, step_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   logic [TIME_W-1:0]   dur_ff, dur_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic                found_ff, found_in;
   logic [CH_IDX_W-1:0] found_ch_ff, found_ch_in;
   logic                tsw_ff, tsw_in;
   logic                pend_valid_ff, pend_valid_in;
   rsp_word_type        pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_ff, rsp_in;

   logic                accept;
   logic                out_free;
   logic                tick_quiet;
   logic                op_unknown;
   logic                last_step;
   logic                hit;
   logic                is_task;
   logic [TIME_W-1:0]   tick_next;
   logic [TIME_W-1:0]   start_deadline;
   logic                emit;
   rsp_word_type        emit_word;

   assign out_free       = !rsp_valid_ff || rsp_ch.ready;
   assign accept         = req_ch.valid && req_ch.ready;
   assign tick_next      = tick_ff + 32'd1;
   assign tick_quiet     = (req_ch.opcode == OP_TICK) && (earliest_ff > tick_next);
   assign op_unknown     = req_ch.opcode > OP_START;
   assign last_step      = step_ff == LAST_CH;
   assign hit            = CMP_W'(step_ff) == CMP_W'(chan_ff);
   assign is_task        = CMP_W'(step_ff) == CMP_W'(task_ff);
   assign start_deadline = tick_ff + dur_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !tick_quiet && !op_unknown) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free && last_step) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free && (op_ff == OP_ALLOC || !tsw_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready  = 1'b0;
      shift         = 1'b0;
      stat.busy     = 1'b1;
      stat.scanning = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            stat.busy    = 1'b0;
         end
         ST_SCAN: begin
            shift         = out_free;
            stat.scanning = 1'b1;
         end
         ST_FLUSH: begin
            shift = 1'b0;
         end
         default: begin
            shift = 1'b0;
         end
      endcase
      stat.step = step_ff;
   end

   // datapath
   always_comb begin
      task_in       = csr_wr_en ? csr_wr_data : task_ff;
      tick_in       = tick_ff;
      earliest_in   = earliest_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      chan_in       = chan_ff;
      dur_in        = dur_ff;
      tag_in        = tag_ff;
      found_in      = found_ff;
      found_ch_in   = found_ch_ff;
      tsw_in        = tsw_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_in        = rsp_ff;
      tail_entry    = head_entry;
      emit          = 1'b0;
      emit_word     = '{kind: KIND_EXPIRY, channel_out: CHAN_W'(step_ff),
                        tag_out: head_entry.tag,
                        event_word: EVENT_BASE | {8'h00, head_entry.tag, 16'h0000},
                        last: 1'b0};

      if (accept) begin
         op_in    = req_ch.opcode;
         chan_in  = req_ch.channel;
         dur_in   = req_ch.duration;
         tag_in   = req_ch.tag_in;
         found_in = 1'b0;
         tsw_in   = 1'b0;
         if (req_ch.opcode == OP_TICK) begin
            tick_in = tick_next;
            if (!tick_quiet) begin
               earliest_in = NO_DEADLINE;
            end
         end
      end

      if (state_ff == ST_SCAN && out_free) begin
         step_in = last_step ? '0 : step_ff + 1'b1;
         case (op_ff)
            OP_TICK: begin
               if (head_entry.status == CH_RUN) begin
                  if (head_entry.deadline <= tick_ff) begin
                     tail_entry.status = CH_ALLOC;
                     if (is_task) begin
                        tsw_in = 1'b1;
                     end else begin
                        emit = 1'b1;
                     end
                  end else if (head_entry.deadline < earliest_ff) begin
                     earliest_in = head_entry.deadline;
                  end
               end
            end
            OP_ALLOC: begin
               if (!found_ff && head_entry.status == CH_FREE) begin
                  tail_entry.status = CH_ALLOC;
                  found_in          = 1'b1;
                  found_ch_in       = step_ff;
               end
            end
            OP_FREE: begin
               if (hit) begin
                  tail_entry.status = CH_FREE;
               end
            end
            OP_SET_TAG: begin
               if (hit) begin
                  tail_entry.tag = tag_ff;
               end
            end
            OP_START: begin
               if (hit && head_entry.status != CH_FREE) begin
                  tail_entry.status   = CH_RUN;
                  tail_entry.deadline = start_deadline;
                  if (start_deadline < earliest_ff) begin
                     earliest_in = start_deadline;
                  end
               end
            end
            default: begin
               tail_entry = head_entry;
            end
         endcase
      end

      if (state_ff == ST_FLUSH && out_free) begin
         if (op_ff == OP_ALLOC) begin
            rsp_valid_in = 1'b1;
            rsp_in       = found_ff ?
               '{kind: KIND_ALLOC, channel_out: CHAN_W'(found_ch_ff), tag_out: '0,
                 event_word: '0, last: 1'b1} :
               '{kind: KIND_NONE_FREE, channel_out: '0, tag_out: '0,
                 event_word: '0, last: 1'b1};
         end else if (tsw_ff) begin
            tsw_in    = 1'b0;
            emit      = 1'b1;
            emit_word = '{kind: KIND_TASK_SWITCH, channel_out: CHAN_W'(task_ff),
                          tag_out: '0, event_word: '0, last: 1'b0};
         end else if (pend_valid_ff) begin
            // the held word is the final one of this item
            rsp_valid_in  = 1'b1;
            rsp_in        = pend_ff;
            rsp_in.last   = 1'b1;
            pend_valid_in = 1'b0;
         end
      end

      // hold one word back so the final one can carry last
      if (emit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
         end
         pend_in       = emit_word;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         task_ff       <= TASK_NONE;
         tick_ff       <= '0;
         earliest_ff   <= NO_DEADLINE;
         step_ff       <= '0;
         found_ff      <= 1'b0;
         tsw_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         task_ff       <= task_in;
         tick_ff       <= tick_in;
         earliest_ff   <= earliest_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
         tsw_ff        <= tsw_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      chan_ff     <= chan_in;
      dur_ff      <= dur_in;
      tag_ff      <= tag_in;
      found_ch_ff <= found_ch_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = rsp_ff.kind;
   assign rsp_ch.channel_out = rsp_ff.channel_out;
   assign rsp_ch.tag_out     = rsp_ff.tag_out;
   assign rsp_ch.event_word  = rsp_ff.event_word;
   assign rsp_ch.last        = rsp_ff.last;

endmodule

>>> hdl/multi_channel_deadline_timer.sv
// Multi-channel deadline timer: rotating ring of channel cells and its head unit.
`timescale 1ns / 1ps
`include "multi_channel_deadline_timer_defines.svh"
// The channel state lives in a ring of NUM_CHANNELS cells that rotates one
// channel per cycle past a single head unit, which applies the current word
// to the channel in front of it. A tick that reaches no deadline, and an
// unknown opcode, finish in the cycle they are accepted. Every other word
// takes one full turn of the ring and a closing flush step, plus a second
// flush step for a trailing task-switch word; the ring pauses while a
// finished response word waits on rsp_ch. A new request word is taken only
// once the previous one has been worked off. Expiry words come in channel
// order, then any task-switch word; a request's last word has last set. The
// user must write task_channel via csr_wr_en / csr_wr_data only while the
// block is idle, which it does not enforce; reset value 32 selects no channel.
module multi_channel_deadline_timer import mdt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   mdt_req_if.sink          req_ch,
   mdt_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   chan_entry_type  cell_q [NUM_CHANNELS];
   chan_entry_type  tail_entry;
   logic            shift;
   ctrl_status_type stat;

   mdt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_entry  (cell_q[0]),
      .tail_entry  (tail_entry),
      .shift       (shift),
      .stat        (stat)
   );

   // advance toward the head; the updated head re-enters at the tail
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
      if (i == NUM_CHANNELS - 1) begin : g_tail
         mdt_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (shift),
            .entry_d (tail_entry),
            .entry_q (cell_q[i])
         );
      end else begin : g_body
         mdt_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (shift),
            .entry_d (cell_q[i+1]),
            .entry_q (cell_q[i])
         );
      end
   end

   `MDT_ASSERT_IMPLY(a_ring_aligned_at_rest, clock, reset, !stat.scanning, stat.step == '0)
   `MDT_ASSERT_NEXT(a_ring_holds_on_stall, clock, reset, stat.scanning && rsp_ch.valid && !rsp_ch.ready, $stable(stat.step))
   `MDT_ASSERT_IMPLY(a_no_accept_while_busy, clock, reset, stat.busy, !req_ch.ready)

endmodule

>>> tb/mdt_expiry_checker.sv
// Response predictor and checker for the multi-channel deadline timer.
`timescale 1ns / 1ps
module mdt_expiry_checker import mdt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   mdt_req_if               req_mon,
   mdt_rsp_if               rsp_mon,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   output int               mismatch_count,
   output int               words_pending,
   output int               words_checked,
   output int               expiries_seen,
   output int               switches_seen,
   output int               none_free_seen
);

   logic [TIME_W-1:0] tick_now;
   logic [TIME_W-1:0] earliest;
   chan_status_type   chan_state [NUM_CHANNELS];
   logic [TIME_W-1:0] chan_deadline [NUM_CHANNELS];
   logic [TAG_W-1:0]  chan_tag [NUM_CHANNELS];
   logic [CSR_W-1:0]  task_sel;
   rsp_word_type      due_words [$];
   int                errors;
   int                checked;
   int                expiries;
   int                switches;
   int                none_free;

   task automatic push_word(input rsp_kind_type kind, input logic [CHAN_W-1:0] ch,
                            input logic [TAG_W-1:0] tag_v);
      rsp_word_type w;
      w.kind        = kind;
      w.channel_out = ch;
      w.tag_out     = tag_v;
      w.event_word  = (kind == KIND_EXPIRY) ? (EVENT_BASE | {8'h00, tag_v, 16'h0000}) : '0;
      w.last        = 1'b0;
      due_words.push_back(w);
   endtask

   // Work out the response words of one accepted request and update the timer copy.
   task automatic predict_timer_words(input logic [OPCODE_W-1:0] op,
                                      input logic [CHAN_W-1:0] ch,
                                      input logic [TIME_W-1:0] dur,
                                      input logic [TAG_W-1:0] tag_v);
      rsp_word_type      w;
      int                first;
      int                i;
      bit                switch_due;
      bit                found;
      logic [TIME_W-1:0] due;
      first      = due_words.size();
      switch_due = 1'b0;
      found      = 1'b0;
      case (op)
         OP_TICK: begin
            tick_now = tick_now + 1;
            if (earliest <= tick_now) begin
               earliest = NO_DEADLINE;
               for (i = 0; i < NUM_CHANNELS; i++) begin
                  if (chan_state[i] == CH_RUN) begin
                     if (chan_deadline[i] <= tick_now) begin
                        chan_state[i] = CH_ALLOC;
                        if (i == int'(task_sel))
                           switch_due = 1'b1;
                        else
                           push_word(KIND_EXPIRY, CHAN_W'(i), chan_tag[i]);
                     end else if (chan_deadline[i] < earliest) begin
                        earliest = chan_deadline[i];
                     end
                  end
               end
               // the task channel reports once, after all expiry words
               if (switch_due)
                  push_word(KIND_TASK_SWITCH, task_sel[CHAN_W-1:0], '0);
            end
         end
         OP_ALLOC: begin
            for (i = 0; i < NUM_CHANNELS; i++) begin
               if (!found && chan_state[i] == CH_FREE) begin
                  chan_state[i] = CH_ALLOC;
                  push_word(KIND_ALLOC, CHAN_W'(i), '0);
                  found = 1'b1;
               end
            end
            if (!found)
               push_word(KIND_NONE_FREE, '0, '0);
         end
         OP_FREE: begin
            chan_state[ch] = CH_FREE;
         end
         OP_SET_TAG: begin
            chan_tag[ch] = tag_v;
         end
         OP_START: begin
            if (chan_state[ch] != CH_FREE) begin
               due               = tick_now + dur;
               chan_deadline[ch] = due;
               chan_state[ch]    = CH_RUN;
               if (due < earliest)
                  earliest = due;
            end
         end
         default: ;
      endcase
      if (due_words.size() > first) begin
         w      = due_words.pop_back();
         w.last = 1'b1;
         due_words.push_back(w);
      end
   endtask

   task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_word_type want;
      int           i;
      if (reset) begin
         tick_now = '0;
         earliest = NO_DEADLINE;
         task_sel = TASK_NONE;
         for (i = 0; i < NUM_CHANNELS; i++) begin
            chan_state[i]    = CH_FREE;
            chan_deadline[i] = '0;
            chan_tag[i]      = '0;
         end
         due_words.delete();
         errors    = 0;
         checked   = 0;
         expiries  = 0;
         switches  = 0;
         none_free = 0;
      end else begin
         if (csr_wr_en)
            task_sel = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            predict_timer_words(req_mon.opcode, req_mon.channel, req_mon.duration,
                                req_mon.tag_in);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_words.size() == 0) begin
               $display("%0t ns: response word with none expected, kind %0d channel %0d",
                        $time, rsp_mon.kind, rsp_mon.channel_out);
               errors++;
            end else begin
               want = due_words.pop_front();
               check_field("kind", TIME_W'(want.kind), TIME_W'(rsp_mon.kind));
               check_field("channel_out", TIME_W'(want.channel_out),
                           TIME_W'(rsp_mon.channel_out));
               check_field("tag_out", TIME_W'(want.tag_out), TIME_W'(rsp_mon.tag_out));
               check_field("event_word", want.event_word, rsp_mon.event_word);
               check_field("last", TIME_W'(want.last), TIME_W'(rsp_mon.last));
               checked++;
               if (want.kind == KIND_EXPIRY)
                  expiries++;
               else if (want.kind == KIND_TASK_SWITCH)
                  switches++;
               else if (want.kind == KIND_NONE_FREE)
                  none_free++;
            end
         end
      end
      mismatch_count <= errors;
      words_pending  <= due_words.size();
      words_checked  <= checked;
      expiries_seen  <= expiries;
      switches_seen  <= switches;
      none_free_seen <= none_free;
   end

endmodule

>>> tb/multi_channel_deadline_timer_test.sv
// Stimulus and verdict for the multi-channel deadline timer.
`timescale 1ns / 1ps
module multi_channel_deadline_timer_test;
   import mdt_pkg::*;

   localparam int SETTLE_CYCLES = 2 * NUM_CHANNELS + 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   mdt_req_if req_ch ();
   mdt_rsp_if rsp_ch ();

   int mismatch_count;
   int words_pending;
   int words_checked;
   int expiries_seen;
   int switches_seen;
   int none_free_seen;
   int words_sent;
   int hold_asked;
   int hold_served;
   int cycle_count;
   bit quiet;
   bit tag_known [NUM_CHANNELS];

   multi_channel_deadline_timer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mdt_expiry_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending),
      .words_checked  (words_checked),
      .expiries_seen  (expiries_seen),
      .switches_seen  (switches_seen),
      .none_free_seen (none_free_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one request word and hold it until the block takes it.
   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [CHAN_W-1:0] ch,
                            input logic [TIME_W-1:0] dur, input logic [TAG_W-1:0] tag_v);
      while (!quiet && $urandom_range(99) < 28) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.opcode   <= op;
      req_ch.channel  <= ch;
      req_ch.duration <= dur;
      req_ch.tag_in   <= tag_v;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      words_sent++;
      if (op == OP_SET_TAG)
         tag_known[ch] = 1'b1;
   endtask

   // Never start a channel whose tag was never written.
   task automatic arm_channel(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] dur);
      if (!tag_known[ch])
         send_word(OP_SET_TAG, ch, $urandom, TAG_W'($urandom_range(255)));
      send_word(OP_START, ch, dur, TAG_W'($urandom_range(255)));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_task_channel(input logic [CSR_W-1:0] sel);
      drain();
      csr_wr_data <= sel;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random_phase(input int count, input int alloc_weight);
      int                n;
      int                pick;
      logic [CHAN_W-1:0] ch;
      logic [TIME_W-1:0] dur;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         // keep most traffic on the low channels that allocate hands out
         ch   = CHAN_W'(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(7));
         dur  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(6);
         if (pick < 35)
            send_word(OP_TICK, CHAN_W'($urandom), $urandom, TAG_W'($urandom));
         else if (pick < 35 + alloc_weight)
            send_word(OP_ALLOC, CHAN_W'($urandom), $urandom, TAG_W'($urandom));
         else if (pick < 43 + alloc_weight)
            send_word(OP_FREE, ch, $urandom, TAG_W'($urandom));
         else if (pick < 57 + alloc_weight)
            send_word(OP_SET_TAG, ch, $urandom, TAG_W'($urandom_range(255)));
         else if (pick < 79 + alloc_weight)
            arm_channel(ch, dur);
         else
            send_word(OPCODE_W'($urandom_range(5, 7)), ch, dur, TAG_W'($urandom));
      end
   endtask

   // Receiver: random back-pressure, plus one long hold on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= quiet || $urandom_range(99) >= 28;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still due", cycle_count, words_pending);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int                i;
      logic [TIME_W-1:0] burst_dur;
      quiet           = 1'b0;
      hold_asked      = 0;
      hold_served     = 0;
      words_sent      = 0;
      for (i = 0; i < NUM_CHANNELS; i++)
         tag_known[i] = 1'b0;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.opcode   <= '0;
      req_ch.channel  <= '0;
      req_ch.duration <= '0;
      req_ch.tag_in   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: no task channel selected yet.
      send_word(OP_TICK, 5'd0, 32'd0, 8'd0);
      send_word(3'd5, 5'd31, 32'hffff_ffff, 8'hff);
      send_word(3'd7, 5'd0, 32'd0, 8'd0);
      send_word(OP_ALLOC, 5'd0, 32'd0, 8'd0);
      send_word(OP_ALLOC, 5'd0, 32'd0, 8'd0);
      send_word(OP_SET_TAG, 5'd0, 32'd0, 8'hff);
      send_word(OP_SET_TAG, 5'd1, 32'd0, 8'h00);
      arm_channel(5'd0, 32'd0);
      send_word(OP_TICK, 5'd0, 32'd0, 8'd0);
      // start on a free channel is dropped
      send_word(OP_START, 5'd2, 32'd5, 8'd0);
      // maximum duration wraps to a deadline already behind the count
      arm_channel(5'd1, 32'hffff_ffff);
      arm_channel(5'd0, 32'd3);
      send_word(OP_TICK, 5'd0, 32'd0, 8'd0);
      // free a running channel; earliest deadline stays stale
      send_word(OP_FREE, 5'd0, 32'd0, 8'd0);
      send_word(OP_SET_TAG, 5'd31, 32'd0, 8'ha5);
      send_word(OP_SET_TAG, 5'd16, 32'd0, 8'h5a);
      send_word(OP_TICK, 5'd0, 32'd0, 8'd0);
      send_word(OP_TICK, 5'd0, 32'd0, 8'd0);
      send_word(OP_FREE, 5'd1, 32'd0, 8'd0);
      send_word(3'd6, 5'd16, 32'h5555_aaaa, 8'h0f);
      send_word(OP_ALLOC, 5'd0, 32'd0, 8'd0);
      arm_channel(5'd0, 32'd2);

      write_task_channel(6'd0);
      run_random_phase(60, 15);

      // Fill every channel, arm all with one duration, expire them together.
      write_task_channel(6'd31);
      hold_asked++;
      burst_dur = $urandom_range(1, 3);
      for (i = 0; i < NUM_CHANNELS + 1; i++)
         send_word(OP_ALLOC, CHAN_W'($urandom), $urandom, TAG_W'($urandom));
      for (i = 0; i < NUM_CHANNELS; i++) begin
         send_word(OP_SET_TAG, CHAN_W'(i), $urandom, TAG_W'($urandom_range(255)));
         arm_channel(CHAN_W'(i), burst_dur);
      end
      for (i = 0; i <= int'(burst_dur); i++)
         send_word(OP_TICK, CHAN_W'($urandom), $urandom, TAG_W'($urandom));

      write_task_channel(6'd63);
      quiet = 1'b1;
      run_random_phase(60, 15);
      quiet = 1'b0;

      write_task_channel(CSR_W'($urandom_range(63)));
      run_random_phase(50, 10);

      drain();
      $display("Sent %0d request words over five task-channel settings, checked %0d responses.",
               words_sent, words_checked);
      $display("Responses included %0d expiries, %0d task switches, %0d failed allocations.",
               expiries_seen, switches_seen, none_free_seen);
      if (mismatch_count == 0 && words_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
